FILE: rtl/nri_pkg.sv
`timescale 1ns / 1ps

package nri_pkg;

    localparam int DIVISOR_WIDTH = 32;
    localparam int FRAC_BITS     = 63;

    localparam int WORD_W   = 64;
    localparam int ACC_W    = 2 * WORD_W;
    localparam int HALF_W   = WORD_W / 2;
    localparam int DIN_W    = 32;
    localparam int D_W      = (DIVISOR_WIDTH < DIN_W) ? DIVISOR_WIDTH : DIN_W;
    localparam int LEN_W    = $clog2(DIN_W + 1);
    localparam int SH_W     = $clog2(WORD_W) + 1;
    localparam int TOL_W    = 32;
    localparam int ITER_W   = 8;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PC_W     = 4;

    localparam logic [DIN_W-1:0]  D_MASK = DIN_W'((65'(1) << D_W) - 65'(1));
    localparam logic [WORD_W-1:0] ONE_FX = WORD_W'(1) << FRAC_BITS;
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(100);
    localparam logic [TOL_W-1:0]  TOL_RST = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = CFG_IDX_W'(1);

    localparam logic [STAT_W-1:0] STAT_CONVERGED = STAT_W'(0);
    localparam logic [STAT_W-1:0] STAT_LIMIT     = STAT_W'(1);
    localparam logic [STAT_W-1:0] STAT_ZERO      = STAT_W'(2);

    // multiplier operand pairs
    typedef enum logic [2:0] {
        M_NONE,
        M_DXL,
        M_DXH,
        M_XLEL,
        M_XLEH,
        M_XHEL,
        M_XHEH
    } t_mop;

    // accumulator and register actions
    typedef enum logic [3:0] {
        A_NOP,
        A_INIT,
        A_CLR,
        A_ADD0,
        A_ADD32,
        A_ADD64,
        A_ERR,
        A_NEXT,
        A_STEP,
        A_OUT,
        A_OUTZ
    } t_aop;

    typedef enum logic [1:0] {
        J_NEXT,
        J_IF,
        J_END
    } t_jmp;

    typedef enum logic [1:0] {
        C_ZERO,
        C_LIMIT,
        C_NOTCONV
    } t_cond;

    typedef struct packed {
        t_mop             mop;
        t_aop             aop;
        t_jmp             jmp;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] L_INIT = PC_W'(0);
    localparam logic [PC_W-1:0] L_LOOP = PC_W'(1);
    localparam logic [PC_W-1:0] L_DONE = PC_W'(12);
    localparam logic [PC_W-1:0] L_ZERO = PC_W'(13);

    // one newton step is d*x (two partial products), the error term,
    // then x*err (four partial products), the update and the change test
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{mop: M_NONE, aop: A_NOP, jmp: J_END, cond: C_ZERO, target: L_INIT};
        case (pc)
            4'd0:  w = '{mop: M_NONE, aop: A_INIT,  jmp: J_IF,   cond: C_ZERO,    target: L_ZERO};
            4'd1:  w = '{mop: M_DXL,  aop: A_CLR,   jmp: J_IF,   cond: C_LIMIT,   target: L_DONE};
            4'd2:  w = '{mop: M_DXH,  aop: A_ADD0,  jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd3:  w = '{mop: M_NONE, aop: A_ADD32, jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd4:  w = '{mop: M_NONE, aop: A_ERR,   jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd5:  w = '{mop: M_XLEL, aop: A_NOP,   jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd6:  w = '{mop: M_XLEH, aop: A_ADD0,  jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd7:  w = '{mop: M_XHEL, aop: A_ADD32, jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd8:  w = '{mop: M_XHEH, aop: A_ADD32, jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd9:  w = '{mop: M_NONE, aop: A_ADD64, jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd10: w = '{mop: M_NONE, aop: A_NEXT,  jmp: J_NEXT, cond: C_ZERO,    target: L_INIT};
            4'd11: w = '{mop: M_NONE, aop: A_STEP,  jmp: J_IF,   cond: C_NOTCONV, target: L_LOOP};
            4'd12: w = '{mop: M_NONE, aop: A_OUT,   jmp: J_END,  cond: C_ZERO,    target: L_INIT};
            4'd13: w = '{mop: M_NONE, aop: A_OUTZ,  jmp: J_END,  cond: C_ZERO,    target: L_INIT};
            default: w = '{mop: M_NONE, aop: A_NOP, jmp: J_END, cond: C_ZERO, target: L_INIT};
        endcase
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] bit_len(input logic [DIN_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < DIN_W; i++) begin
            if (v[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/newton_reciprocal_iterator.sv
`timescale 1ns / 1ps

// channel   | ports                                          | handshake
// ----------+------------------------------------------------+--------------------------
// input     | i_divisor                                      | start & !busy
// result    | o_reciprocal, o_steps_used, o_status           | o_result_valid, one cycle
// config    | i_cfg_index, i_cfg_data                        | i_cfg_valid & o_cfg_ready
//
// a beat runs newton steps until one converges or the iteration limit ends it;
// a zero divisor skips them and gives the zero status; a newton step
// is eleven microcode words, six of them on the one shared 32x32 multiplier
// busy is high from the accepted beat until the strobe; the next beat may be
// accepted at the end of the strobe cycle
// reset is synchronous, active low; results cannot be stalled by the receiver

module newton_reciprocal_iterator
    import nri_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DIN_W-1:0]      i_divisor,
    output logic                  o_result_valid,
    output logic [WORD_W-1:0]     o_reciprocal,
    output logic [ITER_W-1:0]     o_steps_used,
    output logic [STAT_W-1:0]     o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TOL_W-1:0]      i_cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state               r_state;
    logic [PC_W-1:0]      r_pc;
    logic [PC_W-1:0]      n_pc;
    logic [ITER_W-1:0]    r_steps;
    logic                 r_conv;
    logic                 r_out_valid;
    logic [TOL_W-1:0]     r_tol;
    logic [ITER_W-1:0]    r_max;

    logic [DIN_W-1:0]     r_d;
    logic [WORD_W-1:0]    r_x;
    logic [WORD_W-1:0]    r_nx;
    logic [WORD_W-1:0]    r_err;
    logic [ACC_W-1:0]     r_acc;
    logic [WORD_W-1:0]    r_prod;
    logic [WORD_W-1:0]    r_res;
    logic [ITER_W-1:0]    r_res_steps;
    logic [STAT_W-1:0]    r_res_status;

    t_uword               uw;
    logic [HALF_W-1:0]    mul_a;
    logic [HALF_W-1:0]    mul_b;
    logic [ACC_W-1:0]     addend;
    logic [ACC_W-1:0]     acc_sum;
    logic [LEN_W-1:0]     d_len;
    logic [WORD_W-1:0]    guess;
    logic [WORD_W-1:0]    err;
    logic [WORD_W:0]      sum;
    logic [WORD_W-1:0]    q;
    logic                 q_ovf;
    logic [WORD_W-1:0]    nx;
    logic [WORD_W-1:0]    change;
    logic                 conv_now;
    logic                 taken;
    logic                 accept;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state == ST_RUN);
    assign o_cfg_ready = 1'b1;

    assign o_result_valid = r_out_valid;
    assign o_reciprocal   = r_res;
    assign o_steps_used   = r_res_steps;
    assign o_status       = r_res_status;

    assign uw = ucode_rom(r_pc);

    always_comb begin
        case (uw.mop)
            M_DXL:   begin mul_a = r_d;                 mul_b = r_x[HALF_W-1:0];      end
            M_DXH:   begin mul_a = r_d;                 mul_b = r_x[WORD_W-1:HALF_W]; end
            M_XLEL:  begin mul_a = r_x[HALF_W-1:0];     mul_b = r_err[HALF_W-1:0];    end
            M_XLEH:  begin mul_a = r_x[HALF_W-1:0];     mul_b = r_err[WORD_W-1:HALF_W]; end
            M_XHEL:  begin mul_a = r_x[WORD_W-1:HALF_W]; mul_b = r_err[HALF_W-1:0];   end
            M_XHEH:  begin mul_a = r_x[WORD_W-1:HALF_W]; mul_b = r_err[WORD_W-1:HALF_W]; end
            default: begin mul_a = '0;                  mul_b = '0;                   end
        endcase
    end

    always_comb begin
        case (uw.aop)
            A_ADD32: addend = ACC_W'(r_prod) << HALF_W;
            A_ADD64: addend = ACC_W'(r_prod) << WORD_W;
            default: addend = ACC_W'(r_prod);
        endcase
        acc_sum = r_acc + addend;
    end

    // first guess 2^-len, zero once len passes the fraction width
    always_comb begin
        d_len = bit_len(r_d);
        if (32'(d_len) <= FRAC_BITS) begin
            guess = WORD_W'(1) << (SH_W'(FRAC_BITS) - SH_W'(d_len));
        end else begin
            guess = '0;
        end
    end

    // 1 - d*x, clamped at zero
    always_comb begin
        if ((r_acc[ACC_W-1:WORD_W] != '0) || (r_acc[WORD_W-1:0] > ONE_FX)) begin
            err = '0;
        end else begin
            err = ONE_FX - r_acc[WORD_W-1:0];
        end
    end

    always_comb begin
        q_ovf = (r_acc >> (FRAC_BITS + WORD_W)) != '0;
        q     = WORD_W'(r_acc >> FRAC_BITS);
        sum   = {1'b0, r_x} + {1'b0, q};
        if (q_ovf || sum[WORD_W]) begin
            nx = '1;
        end else begin
            nx = sum[WORD_W-1:0];
        end
    end

    always_comb begin
        if (r_nx >= r_x) begin
            change = r_nx - r_x;
        end else begin
            change = r_x - r_nx;
        end
        conv_now = change <= WORD_W'(r_tol);
    end

    always_comb begin
        case (uw.cond)
            C_ZERO:    taken = (r_d == '0);
            C_LIMIT:   taken = (r_steps >= r_max);
            C_NOTCONV: taken = !conv_now;
            default:   taken = 1'b0;
        endcase
        if ((uw.jmp == J_IF) && taken) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pc         <= L_INIT;
            r_steps      <= '0;
            r_conv       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tol        <= TOL_RST;
            r_max        <= MAX_ITER_RST;
            r_res        <= '0;
            r_res_steps  <= '0;
            r_res_status <= STAT_CONVERGED;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TOLERANCE) begin
                    r_tol <= i_cfg_data;
                end else if (i_cfg_index == CFG_MAX_ITER) begin
                    r_max <= i_cfg_data[ITER_W-1:0];
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_RUN;
                        r_pc    <= L_INIT;
                    end
                end
                ST_RUN: begin
                    r_pc <= n_pc;
                    if (uw.aop == A_INIT) begin
                        r_steps <= '0;
                        r_conv  <= 1'b0;
                    end else if (uw.aop == A_STEP) begin
                        r_steps <= r_steps + ITER_W'(1);
                        r_conv  <= conv_now;
                    end else if (uw.aop == A_OUT) begin
                        r_res        <= r_x;
                        r_res_steps  <= r_steps;
                        r_res_status <= r_conv ? STAT_CONVERGED : STAT_LIMIT;
                    end else if (uw.aop == A_OUTZ) begin
                        r_res        <= '1;
                        r_res_steps  <= '0;
                        r_res_status <= STAT_ZERO;
                    end
                    if (uw.jmp == J_END) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= WORD_W'(mul_a) * WORD_W'(mul_b);
        if (accept) begin
            r_d <= i_divisor & D_MASK;
        end
        if (r_state == ST_RUN) begin
            case (uw.aop)
                A_INIT: r_x <= guess;
                A_CLR:  r_acc <= '0;
                A_ADD0, A_ADD32, A_ADD64: r_acc <= acc_sum;
                A_ERR: begin
                    r_err <= err;
                    r_acc <= '0;
                end
                A_NEXT: r_nx <= nx;
                A_STEP: r_x <= r_nx;
                default: begin
                end
            endcase
        end
    end

endmodule
